FILE: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and helpers for the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int RMQ_FRAC_BITS = 14;
  localparam int EW            = 17;
  localparam int QB            = 16;

  localparam logic [1:0] PATH_TRACE = 2'd0;

  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [1:0]         path_used;
  } rmq_out_t;

  typedef logic signed [EW-1:0] rmq_e_t;

  typedef struct packed {
    logic [1:0]       path;
    rmq_e_t [2:0]     e;
  } rmq_ctx_t;

  function automatic logic [1:0] succ(input logic [1:0] i);
    logic [1:0] s;
    case (i)
      2'd0:    s = 2'd1;
      2'd1:    s = 2'd2;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Path select, root argument and the three numerator terms; one stage.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS,
  parameter int AW        = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_in_t       in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [AW-1:0] arg,
  output rmq_ctx_t      ctx
);

  localparam int SA = AW + 1;
  localparam logic signed [SA-1:0] ONE_S = SA'(1) <<< FRAC_BITS;

  logic signed [15:0]   mm [3][3];
  logic signed [SA-1:0] tr;
  logic signed [SA-1:0] arg_s;
  logic [1:0]           piv, j, k;
  logic [AW-1:0]        arg_nxt, arg_r;
  rmq_ctx_t             ctx_nxt, ctx_r;
  logic                 v_r;
  logic                 ready;

  assign mm[0][0] = in_data.m00;
  assign mm[0][1] = in_data.m01;
  assign mm[0][2] = in_data.m02;
  assign mm[1][0] = in_data.m10;
  assign mm[1][1] = in_data.m11;
  assign mm[1][2] = in_data.m12;
  assign mm[2][0] = in_data.m20;
  assign mm[2][1] = in_data.m21;
  assign mm[2][2] = in_data.m22;

  assign tr = SA'(in_data.m00) + SA'(in_data.m11) + SA'(in_data.m22);

  always_comb begin
    piv = 2'd0;
    if (mm[1][1] > mm[0][0]) piv = 2'd1;
    if (mm[2][2] > mm[piv][piv]) piv = 2'd2;
    j = succ(piv);
    k = succ(j);
    if (tr > 0) begin
      arg_s      = tr + ONE_S;
      ctx_nxt.path = PATH_TRACE;
      ctx_nxt.e[0] = EW'(mm[1][2]) - EW'(mm[2][1]);
      ctx_nxt.e[1] = EW'(mm[2][0]) - EW'(mm[0][2]);
      ctx_nxt.e[2] = EW'(mm[0][1]) - EW'(mm[1][0]);
    end else begin
      arg_s      = SA'(mm[piv][piv]) - (SA'(mm[j][j]) + SA'(mm[k][k])) + ONE_S;
      ctx_nxt.path = piv + 2'd1;
      ctx_nxt.e[0] = EW'(mm[j][k]) - EW'(mm[k][j]);
      ctx_nxt.e[1] = EW'(mm[piv][j]) + EW'(mm[j][piv]);
      ctx_nxt.e[2] = EW'(mm[piv][k]) + EW'(mm[k][piv]);
    end
    arg_nxt = (arg_s > 0) ? arg_s[AW-1:0] : '0;
  end

  assign ready    = !v_r || !out_stall;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      arg_r <= arg_nxt;
      ctx_r <= ctx_nxt;
    end
  end

  assign out_valid = v_r;
  assign arg       = arg_r;
  assign ctx       = ctx_r;

endmodule

FILE: hw/rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of arg << FRAC_BITS, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS,
  parameter int AW        = 18,
  parameter int SW2       = 32,
  parameter int RW        = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [AW-1:0] arg,
  input  rmq_ctx_t      in_ctx,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [RW-1:0] root,
  output rmq_ctx_t      out_ctx
);

  logic [RW-1:0]  v_r;
  logic [RW-1:0]  rdy;
  logic [SW2-1:0] rad_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [RW+1:0]  rem_r  [RW];
  rmq_ctx_t       ctx_r  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic           v_p;
    logic [SW2-1:0] rad_p;
    logic [RW-1:0]  root_p;
    logic [RW+1:0]  rem_p;
    rmq_ctx_t       ctx_p;
    logic [RW+1:0]  rem_sh, trial, rem_nxt;
    logic [RW-1:0]  root_nxt;
    logic [SW2-1:0] rad_nxt;
    logic           ge;

    if (s == 0) begin : g_head
      assign v_p    = in_valid;
      assign rad_p  = SW2'(arg) << FRAC_BITS;
      assign root_p = '0;
      assign rem_p  = '0;
      assign ctx_p  = in_ctx;
    end else begin : g_body
      assign v_p    = v_r[s-1];
      assign rad_p  = rad_r[s-1];
      assign root_p = root_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign ctx_p  = ctx_r[s-1];
    end

    if (s == RW - 1) begin : g_tail
      assign rdy[s] = !v_r[s] || !out_stall;
    end else begin : g_mid
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end

    always_comb begin
      rem_sh   = {rem_p[RW-1:0], rad_p[SW2-1 -: 2]};
      trial    = {root_p, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_p[RW-2:0], ge};
      rad_nxt  = rad_p << 2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_p) begin
        rad_r[s]  <= rad_nxt;
        root_r[s] <= root_nxt;
        rem_r[s]  <= rem_nxt;
        ctx_r[s]  <= ctx_p;
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];
  assign out_ctx   = ctx_r[RW-1];

endmodule

FILE: hw/rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three lanes of (|e| * ONE + r) / (2r): setup stage with overflow check,
// then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS,
  parameter int RW        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [RW-1:0]       in_root,
  input  rmq_ctx_t            in_ctx,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RW-1:0]       root,
  output logic [1:0]          path,
  output logic [2:0][QB-1:0]  quo,
  output logic [2:0]          ovf,
  output logic [2:0]          neg
);

  localparam int NS = QB + 1;
  localparam int NW = EW + FRAC_BITS + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;
  logic [RW-1:0] r_r    [NS];
  logic [1:0]    path_r [NS];
  logic [RW:0]   rem_r  [NS][3];
  logic [QB-1:0] low_r  [NS][3];
  logic [QB-1:0] q_r    [NS][3];
  logic [2:0]    ovf_r  [NS];
  logic [2:0]    neg_r  [NS];

  // setup stage
  logic [RW:0]   d0;
  logic [RW:0]   rem0_nxt [3];
  logic [QB-1:0] low0_nxt [3];
  logic [2:0]    ovf0_nxt, neg0_nxt;

  assign d0 = {in_root, 1'b0};

  for (genvar l = 0; l < 3; l++) begin : g_setup
    logic signed [EW-1:0] e;
    logic [EW-1:0]        mag;
    logic [NW-1:0]        num;
    logic [NW-QB-1:0]     hi;

    always_comb begin
      e           = $signed(in_ctx.e[l]);
      neg0_nxt[l] = e < 0;
      mag         = neg0_nxt[l] ? EW'(-e) : EW'(e);
      num         = (NW'(mag) << FRAC_BITS) + NW'(in_root);
      hi          = num[NW-1:QB];
      ovf0_nxt[l] = NW'(hi) >= NW'(d0);
      rem0_nxt[l] = (RW+1)'(hi);
      low0_nxt[l] = num[QB-1:0];
    end
  end

  assign rdy[0] = !v_r[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      r_r[0]    <= in_root;
      path_r[0] <= in_ctx.path;
      ovf_r[0]  <= ovf0_nxt;
      neg_r[0]  <= neg0_nxt;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= rem0_nxt[l];
        low_r[0][l] <= low0_nxt[l];
        q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [RW:0]   d;
    logic [RW:0]   rem_nxt [3];
    logic [QB-1:0] q_nxt   [3];

    assign d = {r_r[s-1], 1'b0};

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW+1:0] rem_sh;
      logic          ge;

      always_comb begin
        rem_sh     = {rem_r[s-1][l], low_r[s-1][l][QB-1]};
        ge         = rem_sh >= {1'b0, d};
        rem_nxt[l] = ge ? (RW+1)'(rem_sh - {1'b0, d}) : rem_sh[RW:0];
        q_nxt[l]   = {q_r[s-1][l][QB-2:0], ge};
      end
    end

    if (s == NS - 1) begin : g_tail
      assign rdy[s] = !v_r[s] || !out_stall;
    end else begin : g_mid
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_r[s-1]) begin
        r_r[s]    <= r_r[s-1];
        path_r[s] <= path_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          low_r[s][l] <= low_r[s-1][l] << 1;
          q_r[s][l]   <= q_nxt[l];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];
  assign root      = r_r[NS-1];
  assign path      = path_r[NS-1];
  assign ovf       = ovf_r[NS-1];
  assign neg       = neg_r[NS-1];
  assign quo[0]    = q_r[NS-1][0];
  assign quo[1]    = q_r[NS-1][1];
  assign quo[2]    = q_r[NS-1][2];

endmodule

FILE: hw/rtl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Sign, saturation and placement of the components; output register.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; #(
  parameter int RW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RW-1:0]      root,
  input  logic [1:0]         path,
  input  logic [2:0][QB-1:0] quo,
  input  logic [2:0]         ovf,
  input  logic [2:0]         neg,
  output logic               out_valid,
  input  logic               out_stall,
  output rmq_out_t           out_data
);

  function automatic logic signed [15:0] sat_lane(input logic [QB-1:0] q,
                                                  input logic ovf_i,
                                                  input logic neg_i);
    logic signed [15:0] res;
    if (neg_i) begin
      res = (ovf_i || q > 16'd32768) ? SAT_MIN : 16'(-q);
    end else begin
      res = (ovf_i || q > 16'd32767) ? SAT_MAX : q;
    end
    return res;
  endfunction

  logic [RW:0]        rp;
  logic signed [15:0] pc;
  logic signed [15:0] ln [3];
  logic signed [15:0] qo [4];
  logic [1:0]         pi, pj, pk;
  rmq_out_t           out_nxt, out_r;
  logic               v_r;
  logic               ready;

  always_comb begin
    rp = ({1'b0, root} + (RW+1)'(1)) >> 1;
    pc = (rp > 32767) ? SAT_MAX : 16'(rp);
    for (int l = 0; l < 3; l++) ln[l] = sat_lane(quo[l], ovf[l], neg[l]);
    pi = path - 2'd1;
    pj = succ(pi);
    pk = succ(pj);
    for (int c = 0; c < 4; c++) qo[c] = '0;
    if (path == PATH_TRACE) begin
      qo[0] = pc;
      qo[1] = ln[0];
      qo[2] = ln[1];
      qo[3] = ln[2];
    end else if (root != '0) begin
      qo[pi + 2'd1] = pc;
      qo[0]         = ln[0];
      qo[pj + 2'd1] = ln[1];
      qo[pk + 2'd1] = ln[2];
    end
    out_nxt.qw        = qo[0];
    out_nxt.qx        = qo[1];
    out_nxt.qy        = qo[2];
    out_nxt.qz        = qo[3];
    out_nxt.path_used = path;
  end

  assign ready    = !v_r || !out_stall;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion, signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock when no stall holds it. The square
// root stages give RW = (AW + FRAC_BITS + 1) / 2 root bits and the divider
// stages QB = 16 quotient bits. Each stage holds its item under stall and
// fills bubbles, so items keep entering while a result waits at the output
// register.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = RMQ_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rmq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rmq_out_t out_data
);

  localparam int AW  = ((FRAC_BITS > 16) ? FRAC_BITS : 17) + 1;
  localparam int SW2 = AW + FRAC_BITS + ((AW + FRAC_BITS) % 2);
  localparam int RW  = SW2 / 2;

  logic               f_valid, f_stall;
  logic [AW-1:0]      f_arg;
  rmq_ctx_t           f_ctx;
  logic               s_valid, s_stall;
  logic [RW-1:0]      s_root;
  rmq_ctx_t           s_ctx;
  logic               d_valid, d_stall;
  logic [RW-1:0]      d_root;
  logic [1:0]         d_path;
  logic [2:0][QB-1:0] d_quo;
  logic [2:0]         d_ovf, d_neg;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .arg       (f_arg),
    .ctx       (f_ctx)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .AW(AW), .SW2(SW2), .RW(RW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .arg       (f_arg),
    .in_ctx    (f_ctx),
    .out_valid (s_valid),
    .out_stall (s_stall),
    .root      (s_root),
    .out_ctx   (s_ctx)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_stall  (s_stall),
    .in_root   (s_root),
    .in_ctx    (s_ctx),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .root      (d_root),
    .path      (d_path),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .neg       (d_neg)
  );

  rmq_back #(.RW(RW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_stall  (d_stall),
    .root      (d_root),
    .path      (d_path),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .neg       (d_neg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_used == PATH_TRACE |-> out_data.qw > 0)
    else $error("trace path gave nonpositive w");

  a_pivot_root_pos: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && d_path == PATH_TRACE |-> d_root != '0)
    else $error("zero root on trace path");

  a_pivot_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_used == 2'd1 |-> !out_data.qx[15])
    else $error("negative pivot component x");

  a_pivot_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_used == 2'd3 |-> !out_data.qz[15])
    else $error("negative pivot component z");
`endif

endmodule

FILE: dv/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Streams matrices through the converter with random idling on both sides
// and checks every quaternion against an in-bench predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int ONE_Q = 1 << RMQ_FRAC_BITS;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  class quat_scoreboard;
    rmq_out_t pending_quats[$];
    int errors;

    function automatic longint root_of(longint a);
      longint v, res, b;
      if (a <= 0) return 0;
      v = a << RMQ_FRAC_BITS;
      res = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function automatic longint div_scaled(longint e, longint r);
      longint mag, q;
      mag = (e < 0) ? -e : e;
      q = ((mag << RMQ_FRAC_BITS) + r) / (r << 1);
      return (e < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] sat(longint v);
      if (v > 32767) return SAT_MAX;
      if (v < -32768) return SAT_MIN;
      return v[15:0];
    endfunction

    function void note_matrix(rmq_in_t d);
      longint m[3][3];
      longint q[4];
      longint tr, r;
      int i, j, k;
      rmq_out_t o;
      m[0][0] = d.m00; m[0][1] = d.m01; m[0][2] = d.m02;
      m[1][0] = d.m10; m[1][1] = d.m11; m[1][2] = d.m12;
      m[2][0] = d.m20; m[2][1] = d.m21; m[2][2] = d.m22;
      q = '{0, 0, 0, 0};
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
        r = root_of(tr + ONE_Q);
        q[3] = (r + 1) >> 1;
        q[0] = div_scaled(m[1][2] - m[2][1], r);
        q[1] = div_scaled(m[2][0] - m[0][2], r);
        q[2] = div_scaled(m[0][1] - m[1][0], r);
        o.path_used = PATH_TRACE;
      end else begin
        i = 0;
        if (m[1][1] > m[0][0]) i = 1;
        if (m[2][2] > m[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        r = root_of(m[i][i] - (m[j][j] + m[k][k]) + ONE_Q);
        if (r != 0) begin
          q[i] = (r + 1) >> 1;
          q[3] = div_scaled(m[j][k] - m[k][j], r);
          q[j] = div_scaled(m[i][j] + m[j][i], r);
          q[k] = div_scaled(m[i][k] + m[k][i], r);
        end
        o.path_used = 2'(i + 1);
      end
      o.qw = sat(q[3]);
      o.qx = sat(q[0]);
      o.qy = sat(q[1]);
      o.qz = sat(q[2]);
      pending_quats.push_back(o);
    endfunction

    function void check_quat(rmq_out_t got);
      rmq_out_t exp_q;
      if (pending_quats.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_q = pending_quats.pop_front();
      if (got.qw !== exp_q.qw) begin
        $error("qw expected %0d actual %0d", exp_q.qw, got.qw); errors++;
      end
      if (got.qx !== exp_q.qx) begin
        $error("qx expected %0d actual %0d", exp_q.qx, got.qx); errors++;
      end
      if (got.qy !== exp_q.qy) begin
        $error("qy expected %0d actual %0d", exp_q.qy, got.qy); errors++;
      end
      if (got.qz !== exp_q.qz) begin
        $error("qz expected %0d actual %0d", exp_q.qz, got.qz); errors++;
      end
      if (got.path_used !== exp_q.path_used) begin
        $error("path_used expected %0d actual %0d", exp_q.path_used, got.path_used);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rmq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rmq_out_t out_data;
  logic     calm;
  longint   cycles;
  quat_scoreboard sb;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.errors = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    calm = 0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rotation_matrix_to_quaternion");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_quat(out_data);
    out_stall <= rst_n && !calm && ($urandom_range(99) < 33);
  end

  // valid stays high from one accepted item to the next unless idling
  task automatic send_matrix(rmq_in_t d);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_matrix(d);
  endtask

  function automatic rmq_in_t mat_from(logic signed [15:0] v[9]);
    rmq_in_t d;
    d = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    return d;
  endfunction

  function automatic logic signed [15:0] rnd_entry();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'sh7fff;
      2: return 16'sh8000;
      default: return 16'($signed($urandom_range(2 * ONE_Q)) - ONE_Q);
    endcase
  endfunction

  // random rotation-like matrix: dominant diagonal on a chosen axis, or none when p is 3
  function automatic rmq_in_t rnd_rotation();
    logic signed [15:0] v[9];
    int p;
    for (int n = 0; n < 9; n++) v[n] = 16'($signed($urandom_range(2 * ONE_Q)) - ONE_Q);
    p = $urandom_range(3);
    if (p < 3) begin
      v[4 * p] = 16'($signed($urandom_range(ONE_Q)));
      for (int n = 0; n < 3; n++)
        if (n != p) v[4 * n] = 16'(-$signed($urandom_range(ONE_Q)));
    end
    return mat_from(v);
  endfunction

  initial begin
    logic signed [15:0] v[9];
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // identity, 180 degree turns about each axis, ties, zero, extremes
    v = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
    send_matrix(mat_from(v));
    v = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384};
    send_matrix(mat_from(v));
    v = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384};
    send_matrix(mat_from(v));
    v = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384};
    send_matrix(mat_from(v));
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(mat_from(v));
    v = '{-16'sd100, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd100};
    send_matrix(mat_from(v));
    v = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
    send_matrix(mat_from(v));
    v = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000};
    send_matrix(mat_from(v));
    v = '{16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 16'sh7fff, 16'sh7fff, 16'sh8000, 0};
    send_matrix(mat_from(v));
    v = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_matrix(mat_from(v));
    v = '{-16'sd1, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 0};
    send_matrix(mat_from(v));
    for (int n = 0; n < 1500; n++) begin
      if (n == 300) calm = 1;
      if (n == 500) calm = 0;
      if (n == 800) begin
        in_valid <= 0;
        while (sb.pending_quats.size() != 0) @(posedge clk);
      end
      if ($urandom_range(3) == 0) begin
        for (int e = 0; e < 9; e++) v[e] = rnd_entry();
        send_matrix(mat_from(v));
      end else begin
        send_matrix(rnd_rotation());
      end
    end
    in_valid <= 0;
    while (sb.pending_quats.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending_quats.size() == 0)
      $display("PASS rotation_matrix_to_quaternion");
    else
      $display("FAIL rotation_matrix_to_quaternion");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
dv/rotation_matrix_to_quaternion_tb.sv
